// File: hdl/akf_pkg.sv
// Shared types, constants and the filter microprogram for the altitude Kalman filter.
package akf_pkg;

   // Datapath operations
   typedef enum logic [2:0] {
      OP_MOVE,
      OP_ADD,
      OP_SUB,
      OP_ADD32,
      OP_SUB32,
      OP_MULDIV,
      OP_MULQ,
      OP_GAIN
   } op_type;

   // Register file selects (sources and destinations)
   typedef enum logic [3:0] {
      SEL_ZERO,
      SEL_ALT,
      SEL_SPD,
      SEL_HH,
      SEL_HV,
      SEL_VV,
      SEL_T0,
      SEL_V2,
      SEL_DELTA,
      SEL_S,
      SEL_RAW,
      SEL_VA,
      SEL_VH
   } sel_type;

   // Tick multiplier: d or 2*d
   typedef enum logic {
      M_D,
      M_2D
   } msel_type;

   // Constant divisor
   typedef enum logic [1:0] {
      DV_1000,
      DV_2000,
      DV_4000
   } dv_type;

   // Gain select
   typedef enum logic {
      K_H,
      K_V
   } ksel_type;

   // Configuration register index
   typedef enum logic {
      REG_MEAS  = 1'b0,
      REG_ACCEL = 1'b1
   } reg_index_type;

   typedef struct packed {
      op_type   op;
      sel_type  dst;
      sel_type  src_a;
      sel_type  src_b;
      msel_type msel;
      dv_type   dv;
      ksel_type ksel;
      logic     last;
   } cmd_type;

   typedef struct packed {
      logic    load_in;
      logic    start;
      logic    out_load;
      cmd_type cmd;
   } ctl_type;

   localparam int STEP_BITS = 5;
   localparam logic [STEP_BITS-1:0] STEP_REINIT = 5'd0;
   localparam logic [STEP_BITS-1:0] STEP_FILTER = 5'd1;

   localparam int REM_BITS = 10;
   localparam logic [REM_BITS:0] DIV_BASE = 11'd1000;
   localparam int GAIN_BITS = 32;

   // Division by 1000 in 16-bit chunks: quotient digit = (x * ceil(2^36/1000)) >> 36,
   // exact for every chunk value x below 1000 * 2^16
   localparam int DIV_CHUNK = 16;
   localparam int DIV_SHIFT = 36;
   localparam int RECIP_BITS = 27;
   localparam logic [RECIP_BITS-1:0] DIV_RECIP = 27'd68719477;

   // 1e10 in Q40.24
   localparam logic signed [63:0] COV_HH_RESET = 64'sd167772160000000000;

   function automatic cmd_type mk(input op_type op, input sel_type dst, input sel_type a,
                                  input sel_type b, input msel_type m, input dv_type dv,
                                  input ksel_type k, input logic last);
      cmd_type c;
      c.op    = op;
      c.dst   = dst;
      c.src_a = a;
      c.src_b = b;
      c.msel  = m;
      c.dv    = dv;
      c.ksel  = k;
      c.last  = last;
      return c;
   endfunction

   // Microprogram: reinit at step 0, predict and update from step 1
   function automatic cmd_type prog(input logic [STEP_BITS-1:0] step);
      cmd_type c;
      c = mk(OP_MOVE, SEL_ALT, SEL_RAW, SEL_ZERO, M_D, DV_1000, K_H, 1'b1);
      case (step)
         5'd0:  c = mk(OP_MOVE,   SEL_ALT,   SEL_RAW,   SEL_ZERO, M_D,  DV_1000, K_H, 1'b1);
         5'd1:  c = mk(OP_MULDIV, SEL_T0,    SEL_VA,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd2:  c = mk(OP_MULDIV, SEL_V2,    SEL_T0,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd3:  c = mk(OP_MULDIV, SEL_T0,    SEL_SPD,   SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd4:  c = mk(OP_ADD32,  SEL_ALT,   SEL_ALT,   SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd5:  c = mk(OP_MULDIV, SEL_T0,    SEL_HV,    SEL_ZERO, M_2D, DV_1000, K_H, 1'b0);
         5'd6:  c = mk(OP_ADD,    SEL_HH,    SEL_HH,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd7:  c = mk(OP_MULDIV, SEL_T0,    SEL_VV,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd8:  c = mk(OP_MULDIV, SEL_T0,    SEL_T0,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd9:  c = mk(OP_ADD,    SEL_HH,    SEL_HH,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd10: c = mk(OP_MULDIV, SEL_T0,    SEL_V2,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd11: c = mk(OP_MULDIV, SEL_T0,    SEL_T0,    SEL_ZERO, M_D,  DV_4000, K_H, 1'b0);
         5'd12: c = mk(OP_ADD,    SEL_HH,    SEL_HH,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd13: c = mk(OP_MULDIV, SEL_T0,    SEL_VV,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd14: c = mk(OP_ADD,    SEL_HV,    SEL_HV,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd15: c = mk(OP_MULDIV, SEL_T0,    SEL_V2,    SEL_ZERO, M_D,  DV_2000, K_H, 1'b0);
         5'd16: c = mk(OP_ADD,    SEL_HV,    SEL_HV,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd17: c = mk(OP_ADD,    SEL_VV,    SEL_VV,    SEL_V2,   M_D,  DV_1000, K_H, 1'b0);
         5'd18: c = mk(OP_SUB32,  SEL_DELTA, SEL_RAW,   SEL_ALT,  M_D,  DV_1000, K_H, 1'b0);
         5'd19: c = mk(OP_ADD,    SEL_S,     SEL_HH,    SEL_VH,   M_D,  DV_1000, K_H, 1'b0);
         5'd20: c = mk(OP_GAIN,   SEL_ZERO,  SEL_HH,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd21: c = mk(OP_GAIN,   SEL_ZERO,  SEL_HV,    SEL_ZERO, M_D,  DV_1000, K_V, 1'b0);
         5'd22: c = mk(OP_MULQ,   SEL_T0,    SEL_DELTA, SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd23: c = mk(OP_ADD32,  SEL_ALT,   SEL_ALT,   SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd24: c = mk(OP_MULQ,   SEL_T0,    SEL_DELTA, SEL_ZERO, M_D,  DV_1000, K_V, 1'b0);
         5'd25: c = mk(OP_ADD32,  SEL_SPD,   SEL_SPD,   SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd26: c = mk(OP_MULQ,   SEL_T0,    SEL_HV,    SEL_ZERO, M_D,  DV_1000, K_V, 1'b0);
         5'd27: c = mk(OP_SUB,    SEL_VV,    SEL_VV,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd28: c = mk(OP_MULQ,   SEL_T0,    SEL_HV,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd29: c = mk(OP_SUB,    SEL_HV,    SEL_HV,    SEL_T0,   M_D,  DV_1000, K_H, 1'b0);
         5'd30: c = mk(OP_MULQ,   SEL_T0,    SEL_HH,    SEL_ZERO, M_D,  DV_1000, K_H, 1'b0);
         5'd31: c = mk(OP_SUB,    SEL_HH,    SEL_HH,    SEL_T0,   M_D,  DV_1000, K_H, 1'b1);
         default: c = mk(OP_MOVE, SEL_ALT, SEL_RAW, SEL_ZERO, M_D, DV_1000, K_H, 1'b1);
      endcase
      return c;
   endfunction

endpackage

// File: hdl/akf_csr.sv
// Configuration registers for the altitude Kalman filter: noise variances.
module akf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [31:0] meas_variance,
   output logic [31:0] accel_variance
);

   logic [31:0] meas_ff, meas_in;
   logic [31:0] accel_ff, accel_in;
   logic        wr_en;
   akf_pkg::reg_index_type idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = akf_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   // Decode write beat
   always_comb begin
      meas_in  = meas_ff;
      accel_in = accel_ff;
      if (wr_en) begin
         unique case (idx)
            akf_pkg::REG_MEAS:  meas_in  = csr_pwdata;
            akf_pkg::REG_ACCEL: accel_in = csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (idx)
         akf_pkg::REG_MEAS:  csr_prdata = meas_ff;
         akf_pkg::REG_ACCEL: csr_prdata = accel_ff;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meas_ff  <= 32'd65536;
         accel_ff <= 32'd65536;
      end else begin
         meas_ff  <= meas_in;
         accel_ff <= accel_in;
      end
   end

   assign meas_variance  = meas_ff;
   assign accel_variance = accel_ff;

endmodule

// File: hdl/akf_dp.sv
// Datapath of the altitude Kalman filter: state registers, multiplier, divider, gain unit.
module akf_dp #(
   parameter int TICK_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  akf_pkg::ctl_type     ctl,
   output logic                 done,
   input  logic [TICK_BITS-1:0] tick_ms,
   input  logic signed [31:0]   raw_altitude,
   input  logic [31:0]          meas_variance,
   input  logic [31:0]          accel_variance,
   output logic signed [31:0]   altitude,
   output logic signed [31:0]   vertical_speed
);

   localparam int MB       = TICK_BITS + 1;
   localparam int PW       = 64 + MB;
   localparam int NCH      = (PW + akf_pkg::DIV_CHUNK - 1) / akf_pkg::DIV_CHUNK;
   localparam int DW       = NCH * akf_pkg::DIV_CHUNK;
   localparam int DXW      = akf_pkg::REM_BITS + akf_pkg::DIV_CHUNK;
   localparam int DPW      = DXW + akf_pkg::RECIP_BITS;
   localparam int PH_BITS  = $clog2(PW + 4);
   localparam logic [PH_BITS-1:0] PH_DIV_END  = PH_BITS'(NCH + 3);
   localparam logic [PH_BITS-1:0] PH_GAIN_END = PH_BITS'(akf_pkg::GAIN_BITS + 1);
   localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
   localparam logic signed [64:0] S32_MIN = -65'sd2147483648;
   localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

   // Architectural state
   logic [TICK_BITS-1:0] last_tick_ff, last_tick_in;
   logic [TICK_BITS-1:0] d_ff, d_in;
   logic signed [31:0]   alt_ff, alt_in, spd_ff, spd_in;
   logic signed [63:0]   hh_ff, hh_in, hv_ff, hv_in, vv_ff, vv_in;
   // Working registers
   logic signed [63:0]   t0_ff, t0_in, v2_ff, v2_in, s_ff, s_in;
   logic signed [31:0]   delta_ff, delta_in, raw_ff, raw_in;
   logic [31:0]          kh_ff, kh_in, kv_ff, kv_in;
   logic                 khn_ff, khn_in, kvn_ff, kvn_in;
   logic signed [31:0]   out_alt_ff, out_alt_in, out_spd_ff, out_spd_in;
   // Sequencing and unit registers
   logic                 busy_ff, busy_in;
   logic [PH_BITS-1:0]   ph_ff, ph_in;
   akf_pkg::cmd_type     cmd_ff, cmd_in;
   logic [63:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic [DW-1:0]        dvd_ff, dvd_in;
   logic [akf_pkg::REM_BITS-1:0] rem_ff, rem_in;
   logic [63:0]          grem_ff, grem_in;
   logic [31:0]          gq_ff, gq_in;

   // Combinational
   logic signed [63:0]   a_val, b_val;
   logic                 a_neg;
   logic [63:0]          a_mag;
   logic [MB-1:0]        m_val;
   logic [31:0]          k_val;
   logic                 k_neg;
   logic [31:0]          mul_x, mul_y;
   logic [63:0]          prod;
   logic signed [64:0]   sum65;
   logic signed [63:0]   alu_res;
   logic [DXW-1:0]       dx, dr;
   logic [DPW-1:0]       dprod;
   logic [akf_pkg::DIV_CHUNK-1:0] dq;
   logic [DW-1:0]        qs;
   logic [63:0]          mq;
   logic                 fm_neg, fm_big;
   logic [62:0]          fm_u;
   logic signed [63:0]   fm_res;
   logic [64:0]          g2;
   logic                 gge, s_pos;
   logic                 wr_en, k_wr;
   logic signed [63:0]   wr_val;
   logic [31:0]          k_res;

   // Operand read
   function automatic logic signed [63:0] rd(input akf_pkg::sel_type sel,
      input logic signed [31:0] alt, input logic signed [31:0] spd,
      input logic signed [63:0] hh, input logic signed [63:0] hv,
      input logic signed [63:0] vv, input logic signed [63:0] t0,
      input logic signed [63:0] v2, input logic signed [31:0] dl,
      input logic signed [63:0] s, input logic signed [31:0] raw,
      input logic [31:0] va, input logic [31:0] vh);
      logic signed [63:0] r;
      case (sel)
         akf_pkg::SEL_ALT:   r = 64'(alt);
         akf_pkg::SEL_SPD:   r = 64'(spd);
         akf_pkg::SEL_HH:    r = hh;
         akf_pkg::SEL_HV:    r = hv;
         akf_pkg::SEL_VV:    r = vv;
         akf_pkg::SEL_T0:    r = t0;
         akf_pkg::SEL_V2:    r = v2;
         akf_pkg::SEL_DELTA: r = 64'(dl);
         akf_pkg::SEL_S:     r = s;
         akf_pkg::SEL_RAW:   r = 64'(raw);
         akf_pkg::SEL_VA:    r = {24'd0, va, 8'd0};
         akf_pkg::SEL_VH:    r = {24'd0, vh, 8'd0};
         default:            r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      a_val = rd(cmd_ff.src_a, alt_ff, spd_ff, hh_ff, hv_ff, vv_ff, t0_ff, v2_ff, delta_ff,
                 s_ff, raw_ff, accel_variance, meas_variance);
      b_val = rd(cmd_ff.src_b, alt_ff, spd_ff, hh_ff, hv_ff, vv_ff, t0_ff, v2_ff, delta_ff,
                 s_ff, raw_ff, accel_variance, meas_variance);
   end

   assign a_neg = a_val[63];
   assign a_mag = a_neg ? (64'd0 - a_val) : a_val;
   assign m_val = (cmd_ff.msel == akf_pkg::M_2D) ? {d_ff, 1'b0} : {1'b0, d_ff};
   assign k_val = (cmd_ff.ksel == akf_pkg::K_V) ? kv_ff : kh_ff;
   assign k_neg = (cmd_ff.ksel == akf_pkg::K_V) ? kvn_ff : khn_ff;

   // Shared 32x32 multiplier: low half in phase 0, high half after
   assign mul_x = (ph_ff == '0) ? a_mag[31:0] : a_mag[63:32];
   assign mul_y = (cmd_ff.op == akf_pkg::OP_MULQ) ? k_val : 32'(m_val);
   assign prod  = 64'(mul_x) * 64'(mul_y);

   // Saturating add and subtract
   always_comb begin
      if (cmd_ff.op == akf_pkg::OP_SUB || cmd_ff.op == akf_pkg::OP_SUB32)
         sum65 = {a_val[63], a_val} - {b_val[63], b_val};
      else
         sum65 = {a_val[63], a_val} + {b_val[63], b_val};
      if (cmd_ff.op == akf_pkg::OP_ADD32 || cmd_ff.op == akf_pkg::OP_SUB32) begin
         if (sum65 > S32_MAX)      alu_res = 64'(S32_MAX);
         else if (sum65 < S32_MIN) alu_res = 64'(S32_MIN);
         else                      alu_res = sum65[63:0];
      end else begin
         if (sum65[64] != sum65[63]) alu_res = sum65[64] ? S64_MIN : S64_MAX;
         else                        alu_res = sum65[63:0];
      end
   end

   // One 16-bit quotient digit per cycle by 1000, through the reciprocal
   assign dx    = {rem_ff, dvd_ff[DW-1 -: akf_pkg::DIV_CHUNK]};
   assign dprod = DPW'(dx) * DPW'(akf_pkg::DIV_RECIP);
   assign dq    = dprod[akf_pkg::DIV_SHIFT +: akf_pkg::DIV_CHUNK];
   assign dr    = dx - DXW'(dq) * DXW'(akf_pkg::DIV_BASE);

   // Scale the quotient for 2000 and 4000
   always_comb begin
      case (cmd_ff.dv)
         akf_pkg::DV_2000: qs = dvd_ff >> 1;
         akf_pkg::DV_4000: qs = dvd_ff >> 2;
         default:          qs = dvd_ff;
      endcase
   end

   assign mq = hi_ff + {32'd0, lo_ff[63:32]};

   // Signed result from magnitude, saturated
   always_comb begin
      if (cmd_ff.op == akf_pkg::OP_MULQ) begin
         fm_neg = a_neg ^ k_neg;
         fm_big = mq[63];
         fm_u   = mq[62:0];
      end else begin
         fm_neg = a_neg;
         fm_big = |qs[DW-1:63];
         fm_u   = qs[62:0];
      end
      if (fm_big)      fm_res = fm_neg ? S64_MIN : S64_MAX;
      else if (fm_neg) fm_res = 64'sd0 - $signed({1'b0, fm_u});
      else             fm_res = $signed({1'b0, fm_u});
   end

   // Gain: one fraction bit per cycle
   assign s_pos = !s_ff[63] && (s_ff != '0);
   assign g2    = {grem_ff, 1'b0};
   assign gge   = (g2 >= {1'b0, s_ff});

   // Sequence the active operation
   always_comb begin
      busy_in  = busy_ff;
      ph_in    = ph_ff;
      cmd_in   = cmd_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      grem_in  = grem_ff;
      gq_in    = gq_ff;
      wr_en    = 1'b0;
      wr_val   = alu_res;
      k_wr     = 1'b0;
      k_res    = '0;
      done     = 1'b0;
      if (busy_ff) begin
         ph_in = ph_ff + 1'b1;
         case (cmd_ff.op)
            akf_pkg::OP_MULDIV: begin
               if (ph_ff == PH_BITS'(0)) begin
                  lo_in = prod;
               end else if (ph_ff == PH_BITS'(1)) begin
                  hi_in = prod;
               end else if (ph_ff == PH_BITS'(2)) begin
                  dvd_in = (DW'(hi_ff) << 32) + DW'(lo_ff);
                  rem_in = '0;
               end else if (ph_ff == PH_DIV_END) begin
                  wr_en  = 1'b1;
                  wr_val = fm_res;
               end else begin
                  dvd_in = {dvd_ff[DW-akf_pkg::DIV_CHUNK-1:0], dq};
                  rem_in = dr[akf_pkg::REM_BITS-1:0];
               end
            end
            akf_pkg::OP_MULQ: begin
               if (ph_ff == PH_BITS'(0)) begin
                  lo_in = prod;
               end else if (ph_ff == PH_BITS'(1)) begin
                  hi_in = prod;
               end else begin
                  wr_en  = 1'b1;
                  wr_val = fm_res;
               end
            end
            akf_pkg::OP_GAIN: begin
               if (ph_ff == PH_BITS'(0)) begin
                  if (!s_pos) begin
                     k_wr = 1'b1;
                  end else if (a_mag >= s_ff) begin
                     k_wr  = 1'b1;
                     k_res = '1;
                  end else begin
                     grem_in = a_mag;
                     gq_in   = '0;
                  end
               end else if (ph_ff == PH_GAIN_END) begin
                  k_wr  = 1'b1;
                  k_res = gq_ff;
               end else begin
                  grem_in = gge ? 64'(g2 - {1'b0, s_ff}) : g2[63:0];
                  gq_in   = {gq_ff[30:0], gge};
               end
            end
            akf_pkg::OP_MOVE: begin
               wr_en  = 1'b1;
               wr_val = a_val;
            end
            default: begin
               wr_en = 1'b1;
            end
         endcase
         if (wr_en || k_wr) begin
            busy_in = 1'b0;
            done    = 1'b1;
         end
      end
      if (ctl.start) begin
         busy_in = 1'b1;
         ph_in   = '0;
         cmd_in  = ctl.cmd;
      end
   end

   // Register file writes
   always_comb begin
      last_tick_in = last_tick_ff;
      d_in         = d_ff;
      raw_in       = raw_ff;
      alt_in       = alt_ff;
      spd_in       = spd_ff;
      hh_in        = hh_ff;
      hv_in        = hv_ff;
      vv_in        = vv_ff;
      t0_in        = t0_ff;
      v2_in        = v2_ff;
      s_in         = s_ff;
      delta_in     = delta_ff;
      kh_in        = kh_ff;
      kv_in        = kv_ff;
      khn_in       = khn_ff;
      kvn_in       = kvn_ff;
      out_alt_in   = out_alt_ff;
      out_spd_in   = out_spd_ff;
      if (ctl.load_in) begin
         last_tick_in = tick_ms;
         d_in         = tick_ms - last_tick_ff;
         raw_in       = raw_altitude;
      end
      if (wr_en) begin
         case (cmd_ff.dst)
            akf_pkg::SEL_ALT:   alt_in   = wr_val[31:0];
            akf_pkg::SEL_SPD:   spd_in   = wr_val[31:0];
            akf_pkg::SEL_HH:    hh_in    = wr_val;
            akf_pkg::SEL_HV:    hv_in    = wr_val;
            akf_pkg::SEL_VV:    vv_in    = wr_val;
            akf_pkg::SEL_T0:    t0_in    = wr_val;
            akf_pkg::SEL_V2:    v2_in    = wr_val;
            akf_pkg::SEL_DELTA: delta_in = wr_val[31:0];
            akf_pkg::SEL_S:     s_in     = wr_val;
            default: ;
         endcase
      end
      if (k_wr) begin
         if (cmd_ff.ksel == akf_pkg::K_V) begin
            kv_in  = k_res;
            kvn_in = a_neg & s_pos;
         end else begin
            kh_in  = k_res;
            khn_in = a_neg & s_pos;
         end
      end
      if (ctl.out_load) begin
         out_alt_in = alt_ff;
         out_spd_in = spd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         ph_ff        <= '0;
         last_tick_ff <= '0;
         alt_ff       <= '0;
         spd_ff       <= '0;
         hh_ff        <= akf_pkg::COV_HH_RESET;
         hv_ff        <= '0;
         vv_ff        <= '0;
      end else begin
         busy_ff      <= busy_in;
         ph_ff        <= ph_in;
         last_tick_ff <= last_tick_in;
         alt_ff       <= alt_in;
         spd_ff       <= spd_in;
         hh_ff        <= hh_in;
         hv_ff        <= hv_in;
         vv_ff        <= vv_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      d_ff       <= d_in;
      raw_ff     <= raw_in;
      t0_ff      <= t0_in;
      v2_ff      <= v2_in;
      s_ff       <= s_in;
      delta_ff   <= delta_in;
      kh_ff      <= kh_in;
      kv_ff      <= kv_in;
      khn_ff     <= khn_in;
      kvn_ff     <= kvn_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      grem_ff    <= grem_in;
      gq_ff      <= gq_in;
      out_alt_ff <= out_alt_in;
      out_spd_ff <= out_spd_in;
   end

   assign altitude       = out_alt_ff;
   assign vertical_speed = out_spd_ff;

endmodule

// File: hdl/akf_ctrl.sv
// Controller of the altitude Kalman filter: handshakes and microprogram sequencing.
module akf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_reinit,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output akf_pkg::ctl_type ctl,
   input  logic             done
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type                     state_ff, state_in;
   logic [akf_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept, out_free;
   akf_pkg::cmd_type              cur;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign cur       = akf_pkg::prog(step_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl.load_in  = accept;
      ctl.start    = 1'b0;
      ctl.out_load = 1'b0;
      ctl.cmd      = cur;
      // Drop the result beat once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in  = req_reinit ? akf_pkg::STEP_REINIT : akf_pkg::STEP_FILTER;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            ctl.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (done) begin
               if (cur.last) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (out_free) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/altitude_kalman_filter_top.sv
// Altitude Kalman filter: two-state barometric altitude and vertical speed estimator.
//
// Input beat (req_): tick_ms, raw_altitude (Q16.16), reinit. Taken when req_valid is
// high and req_stall low; req_stall is high from the accepting edge until the result
// is loaded into the output register.
// Result beat (rsp_): altitude and vertical_speed (Q16.16), one per input beat, held
// in an output register until taken (rsp_valid high, rsp_stall low). A new input beat
// is taken while a result still waits; its own result waits until the register frees.
// A reinit beat runs one microstep; a filter beat runs 31 microsteps on one shared
// 32x32 multiplier: 10 multiply-divide steps, each dividing by 1000 one 16-bit digit
// per cycle, two bit-serial gains, which end early when one saturates or its
// denominator is not positive, and the gain multiplies, adds and subtracts.
// A new input beat is not taken until the result of the last one is loaded into the
// output register, and that load waits while the receiver stalls a waiting result.
// Reset (synchronous) clears the estimates, sets the altitude covariance to 1e10 and
// both variances to 1.0. The user is to write the variances through the csr_ port
// only while idle; the block itself does not enforce this.
module altitude_kalman_filter_top #(
   parameter int TICK_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [TICK_BITS-1:0] req_tick_ms,
   input  logic signed [31:0]   req_raw_altitude,
   input  logic                 req_reinit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_altitude,
   output logic signed [31:0]   rsp_vertical_speed,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   akf_pkg::ctl_type ctl;
   logic             done;
   logic [31:0]      meas_variance, accel_variance;

   akf_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .meas_variance  (meas_variance),
      .accel_variance (accel_variance)
   );

   akf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_reinit (req_reinit),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .ctl        (ctl),
      .done       (done)
   );

   akf_dp #(
      .TICK_BITS (TICK_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .done           (done),
      .tick_ms        (req_tick_ms),
      .raw_altitude   (req_raw_altitude),
      .meas_variance  (meas_variance),
      .accel_variance (accel_variance),
      .altitude       (rsp_altitude),
      .vertical_speed (rsp_vertical_speed)
   );

endmodule

// File: verif/tb_top.sv
// Testbench for the altitude Kalman filter: directed and random beats checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_top;

   localparam int TB_TICK_BITS = 8;
   localparam int STALL_LIMIT = 20000;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [TB_TICK_BITS-1:0] req_tick_ms;
   logic signed [31:0]      req_raw_altitude;
   logic                    req_reinit;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [31:0]      rsp_altitude;
   logic signed [31:0]      rsp_vertical_speed;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [2:0]              csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   altitude_kalman_filter_top #(.TICK_BITS(TB_TICK_BITS)) dut (.*);

   typedef struct {
      logic [31:0] altitude;
      logic [31:0] speed;
   } estimate_type;

   // Filter predictor and store of expected estimates
   class kalman_scoreboard;
      logic [31:0] meas_var;
      logic [31:0] accel_var;
      logic [TB_TICK_BITS-1:0] prev_tick;
      longint alt;
      longint spd;
      longint p_hh;
      longint p_hv;
      longint p_vv;
      estimate_type pending[$];
      int errors;

      function new();
         meas_var  = 32'd65536;
         accel_var = 32'd65536;
         prev_tick = '0;
         alt = 0;
         spd = 0;
         p_hh = akf_pkg::COV_HH_RESET;
         p_hv = 0;
         p_vv = 0;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function logic [63:0] magnitude(input longint a);
         return a < 0 ? 64'd0 - 64'(a) : 64'(a);
      endfunction

      function longint signed_of(input logic [63:0] u, input bit neg);
         if (neg) begin
            if (u[63]) return 64'sh8000000000000000;
            return -longint'(u);
         end
         if (u[63]) return 64'sh7fffffffffffffff;
         return longint'(u);
      endfunction

      function longint add_sat(input longint a, input longint b);
         logic signed [64:0] w;
         w = {a[63], a} + {b[63], b};
         if (w > 65'sh07fffffffffffffff) return 64'sh7fffffffffffffff;
         if (w < -65'sh08000000000000000) return 64'sh8000000000000000;
         return longint'(w[63:0]);
      endfunction

      function longint sub_sat(input longint a, input longint b);
         logic signed [64:0] w;
         w = {a[63], a} - {b[63], b};
         if (w > 65'sh07fffffffffffffff) return 64'sh7fffffffffffffff;
         if (w < -65'sh08000000000000000) return 64'sh8000000000000000;
         return longint'(w[63:0]);
      endfunction

      function longint clamp32(input longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      // Exact a*m/dv, truncated toward zero, saturated to 64 bits
      function longint scale(input longint a, input int unsigned m, input int unsigned dv);
         logic [127:0] q;
         q = (128'(magnitude(a)) * 128'(m)) / 128'(dv);
         if (q[127:64] != 0) return signed_of(64'hffffffffffffffff, a < 0);
         return signed_of(q[63:0], a < 0);
      endfunction

      function longint gain_mul(input longint a, input logic [31:0] k, input bit kneg);
         logic [127:0] q;
         q = (128'(magnitude(a)) * 128'(k)) >> 32;
         return signed_of(q[63:0], (a < 0) != kneg);
      endfunction

      function logic [31:0] gain_of(input longint p, input logic [63:0] s);
         logic [127:0] q;
         if (magnitude(p) >= s) return 32'hffffffff;
         q = (128'(magnitude(p)) << 32) / 128'(s);
         return q[31:0];
      endfunction

      function void set_reg(input akf_pkg::reg_index_type idx, input logic [31:0] value);
         if (idx == akf_pkg::REG_MEAS) meas_var = value;
         else accel_var = value;
      endfunction

      // Advance the filter by one accepted beat and queue its estimate
      function void note_beat(input logic [TB_TICK_BITS-1:0] tick, input logic [31:0] raw_bits,
                              input logic reinit);
         int unsigned d;
         longint raw, va, vh, v2, ohv, ovv, s, delta;
         logic [31:0] kh, kv;
         bit khn, kvn;
         estimate_type e;
         d = int'(TB_TICK_BITS'(tick - prev_tick));
         prev_tick = tick;
         raw = longint'(signed'(raw_bits));
         if (reinit) begin
            alt = raw;
         end else begin
            va = longint'({32'd0, accel_var}) << 8;
            vh = longint'({32'd0, meas_var}) << 8;
            v2 = scale(scale(va, d, 1000), d, 1000);
            ohv = p_hv;
            ovv = p_vv;
            kh = 0;
            kv = 0;
            khn = 0;
            kvn = 0;
            alt = clamp32(alt + scale(spd, d, 1000));
            p_hh = add_sat(p_hh, scale(ohv, 2 * d, 1000));
            p_hh = add_sat(p_hh, scale(scale(ovv, d, 1000), d, 1000));
            p_hh = add_sat(p_hh, scale(scale(v2, d, 1000), d, 4000));
            p_hv = add_sat(p_hv, scale(ovv, d, 1000));
            p_hv = add_sat(p_hv, scale(v2, d, 2000));
            p_vv = add_sat(p_vv, v2);
            delta = clamp32(raw - alt);
            s = add_sat(p_hh, vh);
            // Zero gains when the denominator is not positive
            if (s > 0) begin
               kh = gain_of(p_hh, 64'(s));
               khn = p_hh < 0;
               kv = gain_of(p_hv, 64'(s));
               kvn = p_hv < 0;
            end
            alt = clamp32(alt + gain_mul(delta, kh, khn));
            spd = clamp32(spd + gain_mul(delta, kv, kvn));
            ohv = p_hv;
            p_vv = sub_sat(p_vv, gain_mul(ohv, kv, kvn));
            p_hv = sub_sat(p_hv, gain_mul(ohv, kh, khn));
            p_hh = sub_sat(p_hh, gain_mul(p_hh, kh, khn));
         end
         e.altitude = alt[31:0];
         e.speed = spd[31:0];
         pending.push_back(e);
      endfunction

      task check_estimate(input logic [31:0] a, input logic [31:0] v);
         estimate_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result alt=%h spd=%h", a, v));
         end else begin
            e = pending.pop_front();
            if (a !== e.altitude)
               report($sformatf("altitude %h, want %h", a, e.altitude));
            if (v !== e.speed)
               report($sformatf("vertical_speed %h, want %h", v, e.speed));
         end
      endtask
   endclass

   kalman_scoreboard sb;
   int idle_pct;
   int quiet_cycles = 0;
   logic [TB_TICK_BITS-1:0] next_tick;
   logic signed [31:0] last_raw;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      sb = new();
   end

   // Take results at random stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Track accepted beats on both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_beat(req_tick_ms, req_raw_altitude, req_reinit);
         if (rsp_valid && !rsp_stall) sb.check_estimate(rsp_altitude, rsp_vertical_speed);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // Present one beat and hold it until taken
   task send_beat(input logic [TB_TICK_BITS-1:0] tick, input logic [31:0] raw,
                  input logic reinit);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick_ms <= tick;
      req_raw_altitude <= raw;
      req_reinit <= reinit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task drain;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task write_reg(input akf_pkg::reg_index_type idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, value);
   endtask

   task set_variances(input logic [31:0] meas, input logic [31:0] accel);
      drain();
      write_reg(akf_pkg::REG_MEAS, meas);
      write_reg(akf_pkg::REG_ACCEL, accel);
   endtask

   // Mostly tracking sequences near the last altitude, with noise and reinit beats
   task random_beats(input int count);
      logic [31:0] raw;
      int sel;
      for (int i = 0; i < count; i++) begin
         idle_pct = (i >= count / 3 && i < count / 2) ? 0 : 31;
         sel = $urandom_range(99);
         if (sel < 8) next_tick = TB_TICK_BITS'($urandom);
         else if (sel < 12) next_tick = next_tick;
         else next_tick = TB_TICK_BITS'(next_tick + $urandom_range(1, 40));
         sel = $urandom_range(99);
         if (sel < 15) raw = $urandom;
         else if (sel < 20) raw = ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
         else raw = last_raw + $signed($urandom_range(262144)) - 32'sd131072;
         last_raw = raw;
         send_beat(next_tick, raw, $urandom_range(99) < 12);
         if (i == count / 4) drain();
      end
   endtask

   initial begin
      idle_pct = 31;
      reset = 1'b1;
      req_valid = 1'b0;
      req_tick_ms = '0;
      req_raw_altitude = '0;
      req_reinit = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      next_tick = '0;
      last_raw = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero and wrapped tick steps, reinit
      send_beat(8'd0, 32'h00000000, 1'b0);
      send_beat(8'd10, 32'h00640000, 1'b0);
      send_beat(8'd20, 32'h7fffffff, 1'b0);
      send_beat(8'd20, 32'h80000000, 1'b0);
      send_beat(8'd255, 32'h80000000, 1'b1);
      send_beat(8'd4, 32'h7fffffff, 1'b0);
      send_beat(8'd3, 32'h7fffffff, 1'b0);
      send_beat(8'd3, 32'h7fffffff, 1'b1);
      send_beat(8'd13, 32'h00010000, 1'b0);
      send_beat(8'd23, 32'hffff0000, 1'b0);
      set_variances(32'd1, 32'hffffffff);
      send_beat(8'd40, 32'h00100000, 1'b0);
      send_beat(8'd35, 32'hfff00000, 1'b0);
      send_beat(8'd100, 32'h7fffffff, 1'b0);
      send_beat(8'd200, 32'h80000000, 1'b0);
      set_variances(32'hffffffff, 32'd0);
      send_beat(8'd201, 32'h00000000, 1'b0);
      send_beat(8'd202, 32'h55555555, 1'b0);
      send_beat(8'd203, 32'haaaaaaaa, 1'b1);
      send_beat(8'd210, 32'h00000000, 1'b0);

      set_variances(32'd65536, 32'd65536);
      random_beats(400);
      set_variances(32'd1, 32'd0);
      random_beats(300);
      set_variances(32'hffffffff, 32'hffffffff);
      random_beats(300);
      set_variances($urandom_range(1, 32'h00ffffff), $urandom_range(0, 32'h00ffffff));
      random_beats(400);
      set_variances($urandom | 32'd1, $urandom);
      random_beats(400);

      drain();
      if (sb.pending.size() != 0) sb.report("expected results left over");
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
